### hdl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition in this cycle implies property in the same cycle
`define DSA_ASSERT_SAME(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("%m: same-cycle check failed");

// condition in this cycle implies property in the next cycle
`define DSA_ASSERT_NEXT(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("%m: next-cycle check failed");

`endif

### hdl/dsa_pkg.sv
// shared types and constants of the descriptor slot allocator
package dsa_pkg;

    // sizes
    localparam int FREE_DEPTH  = 1024;
    localparam int OFFSET_BITS = 24;
    localparam int FREE_AW     = $clog2(FREE_DEPTH);
    localparam int CNT_W       = $clog2(FREE_DEPTH + 1);
    localparam int LIMIT_W     = 25;
    localparam int STRIDE_W    = 13;
    localparam int ADDR_W      = 64;
    localparam int COUNT_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int PROD_W      = OFFSET_BITS + STRIDE_W;

    // largest usable slot count so every offset fits
    localparam logic [LIMIT_W-1:0] LIMIT_CAP = LIMIT_W'(1) << OFFSET_BITS;

    // configuration reset values
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(32);

    // request codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_GRANTED = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_FREED   = 2'd2,
        ST_DROPPED = 2'd3
    } status_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOT_LIMIT  = 2'd0,
        CFG_SLOT_STRIDE = 2'd1,
        CFG_CPU_BASE    = 2'd2,
        CFG_GPU_BASE    = 2'd3
    } cfg_idx_t;

    // free stack commands
    typedef struct packed {
        logic                   push;
        logic                   pop;
        logic [OFFSET_BITS-1:0] push_data;
    } stk_ctl_t;

    // free stack status
    typedef struct packed {
        logic                   empty;
        logic                   full;
        logic [OFFSET_BITS-1:0] top;
    } stk_stat_t;

    // decided result handed to the address stages
    typedef struct packed {
        status_t                status;
        logic                   granted;
        logic [OFFSET_BITS-1:0] offset;
    } res_t;

endpackage

### hdl/descriptor_slot_allocator.sv
// descriptor slot allocator: bump counter with a lifo free list, top level
// a result passes the input register, the product stage and the result register
// throughput: one item per cycle unless out_ready stalls; the free stack top is
// a registered read bypassing the last push, so pops and pushes run back to back
// reset: rst_n async low clears stage valids, counters, limit and bases; stride to 32
module descriptor_slot_allocator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [dsa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dsa_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               req_type,
    input  logic [dsa_pkg::COUNT_W-1:0]        alloc_count,
    input  logic [dsa_pkg::OFFSET_BITS-1:0]    free_offset,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         status,
    output logic [dsa_pkg::OFFSET_BITS-1:0]    slot_offset,
    output logic [dsa_pkg::ADDR_W-1:0]         cpu_address,
    output logic [dsa_pkg::ADDR_W-1:0]         gpu_address
);

    logic [dsa_pkg::LIMIT_W-1:0]      slot_limit_reg;
    logic [dsa_pkg::STRIDE_W-1:0]     slot_stride_reg;
    logic [dsa_pkg::ADDR_W-1:0]       cpu_base_reg;
    logic [dsa_pkg::ADDR_W-1:0]       gpu_base_reg;

    logic                             v1_reg;
    logic                             req_type_reg;
    logic [dsa_pkg::COUNT_W-1:0]      alloc_count_reg;
    logic [dsa_pkg::OFFSET_BITS-1:0]  free_offset_reg;

    logic                             s2_ready;
    logic                             fire1;
    logic                             bump_fits;
    logic                             bump_take;
    logic [dsa_pkg::OFFSET_BITS-1:0]  bump_base;
    dsa_pkg::stk_ctl_t                stk_ctl;
    dsa_pkg::stk_stat_t               stk_stat;
    dsa_pkg::res_t                    res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_limit_reg  <= '0;
            slot_stride_reg <= dsa_pkg::STRIDE_RESET;
            cpu_base_reg    <= '0;
            gpu_base_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (dsa_pkg::cfg_idx_t'(cfg_index))
                dsa_pkg::CFG_SLOT_LIMIT:  slot_limit_reg  <= cfg_data[dsa_pkg::LIMIT_W-1:0];
                dsa_pkg::CFG_SLOT_STRIDE: slot_stride_reg <= cfg_data[dsa_pkg::STRIDE_W-1:0];
                dsa_pkg::CFG_CPU_BASE:    cpu_base_reg    <= cfg_data;
                dsa_pkg::CFG_GPU_BASE:    gpu_base_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    assign in_ready = !v1_reg || s2_ready;
    assign fire1    = v1_reg && s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            req_type_reg    <= req_type;
            alloc_count_reg <= alloc_count;
            free_offset_reg <= free_offset;
        end
    end

    // stack and bump commands, taken only when the item moves on
    assign stk_ctl.push      = fire1 && (req_type_reg == dsa_pkg::REQ_FREE) && !stk_stat.full;
    assign stk_ctl.pop       = fire1 && (req_type_reg == dsa_pkg::REQ_ALLOC) && !stk_stat.empty;
    assign stk_ctl.push_data = free_offset_reg;
    assign bump_take         = fire1 && (req_type_reg == dsa_pkg::REQ_ALLOC)
                               && stk_stat.empty && bump_fits;

    // result decision: free, reuse of a freed slot, or bump
    always_comb
    begin
        res.status  = dsa_pkg::ST_NOSPACE;
        res.granted = 1'b0;
        res.offset  = '0;
        if (req_type_reg == dsa_pkg::REQ_FREE)
        begin
            res.status = stk_stat.full ? dsa_pkg::ST_DROPPED : dsa_pkg::ST_FREED;
        end
        else if (!stk_stat.empty)
        begin
            res.status  = dsa_pkg::ST_GRANTED;
            res.granted = 1'b1;
            res.offset  = stk_stat.top;
        end
        else if (bump_fits)
        begin
            res.status  = dsa_pkg::ST_GRANTED;
            res.granted = 1'b1;
            res.offset  = bump_base;
        end
    end

    dsa_free_stack u_free_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (stk_ctl),
        .stat  (stk_stat)
    );

    dsa_bump u_bump (
        .clk         (clk),
        .rst_n       (rst_n),
        .slot_limit  (slot_limit_reg),
        .alloc_count (alloc_count_reg),
        .take        (bump_take),
        .fits        (bump_fits),
        .base_slot   (bump_base)
    );

    dsa_addr_gen u_addr_gen (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (v1_reg),
        .in_ready    (s2_ready),
        .res         (res),
        .slot_stride (slot_stride_reg),
        .cpu_base    (cpu_base_reg),
        .gpu_base    (gpu_base_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .slot_offset (slot_offset),
        .cpu_address (cpu_address),
        .gpu_address (gpu_address)
    );

endmodule

### hdl/dsa_free_stack.sv
// lifo of freed slot offsets held in a memory with a registered top read
module dsa_free_stack (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dsa_pkg::stk_ctl_t    ctl,
    output dsa_pkg::stk_stat_t   stat
);

    logic [dsa_pkg::OFFSET_BITS-1:0] mem [dsa_pkg::FREE_DEPTH];

    logic [dsa_pkg::CNT_W-1:0]       count_reg;
    logic [dsa_pkg::CNT_W-1:0]       count_next;
    logic [dsa_pkg::CNT_W-1:0]       top_idx;
    logic [dsa_pkg::FREE_AW-1:0]     rd_addr;
    logic [dsa_pkg::OFFSET_BITS-1:0] rd_data_reg;
    logic [dsa_pkg::OFFSET_BITS-1:0] byp_data_reg;
    logic                            byp_valid_reg;

    // fill count
    always_comb
    begin
        if (ctl.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.pop)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // next top lives one below the new fill count
    assign top_idx = count_next - 1'b1;
    assign rd_addr = top_idx[dsa_pkg::FREE_AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            byp_valid_reg <= ctl.push;
        end
    end

    // memory write and registered read, pushed item kept aside for bypass
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[count_reg[dsa_pkg::FREE_AW-1:0]] <= ctl.push_data;
        end
        rd_data_reg  <= mem[rd_addr];
        byp_data_reg <= ctl.push_data;
    end

    // status toward the decision logic
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == dsa_pkg::CNT_W'(dsa_pkg::FREE_DEPTH));
    assign stat.top   = byp_valid_reg ? byp_data_reg : rd_data_reg;

endmodule

### hdl/dsa_bump.sv
// bump counter with bound check against the clamped slot limit
module dsa_bump (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [dsa_pkg::LIMIT_W-1:0]       slot_limit,
    input  logic [dsa_pkg::COUNT_W-1:0]       alloc_count,
    input  logic                              take,
    output logic                              fits,
    output logic [dsa_pkg::OFFSET_BITS-1:0]   base_slot
);

    logic [dsa_pkg::LIMIT_W-1:0] next_free_slot_reg;
    logic [dsa_pkg::LIMIT_W-1:0] next_free_slot_next;
    logic [dsa_pkg::LIMIT_W-1:0] limit_eff;
    logic [dsa_pkg::LIMIT_W:0]   run_end;

    // clamp the limit so every granted offset fits its field
    assign limit_eff = (slot_limit > dsa_pkg::LIMIT_CAP) ? dsa_pkg::LIMIT_CAP : slot_limit;

    // end of the requested run and bound check
    assign run_end = {1'b0, next_free_slot_reg} + (dsa_pkg::LIMIT_W + 1)'(alloc_count);
    assign fits    = (alloc_count != '0) && (run_end <= {1'b0, limit_eff});

    assign base_slot = next_free_slot_reg[dsa_pkg::OFFSET_BITS-1:0];

    assign next_free_slot_next = take ? run_end[dsa_pkg::LIMIT_W-1:0] : next_free_slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_free_slot_reg <= '0;
        end
        else
        begin
            next_free_slot_reg <= next_free_slot_next;
        end
    end

endmodule

### hdl/dsa_addr_gen.sv
// product stage and base add stage feeding the result register
module dsa_addr_gen (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  dsa_pkg::res_t                      res,
    input  logic [dsa_pkg::STRIDE_W-1:0]       slot_stride,
    input  logic [dsa_pkg::ADDR_W-1:0]         cpu_base,
    input  logic [dsa_pkg::ADDR_W-1:0]         gpu_base,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         status,
    output logic [dsa_pkg::OFFSET_BITS-1:0]    slot_offset,
    output logic [dsa_pkg::ADDR_W-1:0]         cpu_address,
    output logic [dsa_pkg::ADDR_W-1:0]         gpu_address
);

    logic                                v2_reg;
    logic                                v3_reg;
    logic                                s3_ready;
    dsa_pkg::res_t                       res2_reg;
    logic [dsa_pkg::PROD_W-1:0]          prod2_reg;
    logic [dsa_pkg::PROD_W-1:0]          prod_next;
    logic [1:0]                          status3_reg;
    logic [dsa_pkg::OFFSET_BITS-1:0]     offset3_reg;
    logic [dsa_pkg::ADDR_W-1:0]          cpu3_reg;
    logic [dsa_pkg::ADDR_W-1:0]          gpu3_reg;
    logic [dsa_pkg::ADDR_W-1:0]          cpu_next;
    logic [dsa_pkg::ADDR_W-1:0]          gpu_next;

    // stage flow control
    assign s3_ready = !v3_reg || out_ready;
    assign in_ready = !v2_reg || s3_ready;

    // offset times stride
    assign prod_next = dsa_pkg::PROD_W'(res.offset) * dsa_pkg::PROD_W'(slot_stride);

    // base add, zero unless granted
    assign cpu_next = res2_reg.granted ? cpu_base + dsa_pkg::ADDR_W'(prod2_reg) : '0;
    assign gpu_next = res2_reg.granted ? gpu_base + dsa_pkg::ADDR_W'(prod2_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                v2_reg <= in_valid;
            end
            if (s3_ready)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            res2_reg  <= res;
            prod2_reg <= prod_next;
        end
        if (s3_ready && v2_reg)
        begin
            status3_reg <= res2_reg.status;
            offset3_reg <= res2_reg.offset;
            cpu3_reg    <= cpu_next;
            gpu3_reg    <= gpu_next;
        end
    end

    assign out_valid   = v3_reg;
    assign status      = status3_reg;
    assign slot_offset = offset3_reg;
    assign cpu_address = cpu3_reg;
    assign gpu_address = gpu3_reg;

endmodule

### hdl/dsa_checker.sv
// port-level checks for the descriptor slot allocator, bound to the top level
`include "assert_macros.svh"

module dsa_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [1:0]                         status,
    input logic [dsa_pkg::OFFSET_BITS-1:0]    slot_offset,
    input logic [dsa_pkg::ADDR_W-1:0]         cpu_address,
    input logic [dsa_pkg::ADDR_W-1:0]         gpu_address
);

    // a stalled result holds
    `DSA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(status) && $stable(slot_offset)
        && $stable(cpu_address) && $stable(gpu_address))

    // non-grant results carry zero offset and addresses
    `DSA_ASSERT_SAME(a_zero_unless_grant, clk, rst_n,
        out_valid && (status != dsa_pkg::ST_GRANTED),
        (slot_offset == '0) && (cpu_address == '0) && (gpu_address == '0))

    // an empty result register means the pipe can take an item
    `DSA_ASSERT_SAME(a_ready_when_drained, clk, rst_n, !out_valid, in_ready)

    // an offered item that is not taken stays offered
    `DSA_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid)

endmodule

bind descriptor_slot_allocator dsa_checker u_dsa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .slot_offset (slot_offset),
    .cpu_address (cpu_address),
    .gpu_address (gpu_address)
);

### tb/tb_descriptor_slot_allocator.sv
// self-checking testbench of the descriptor slot allocator with a scoreboard class
`timescale 1ns / 100ps

module tb_descriptor_slot_allocator;

    localparam int STALL_LIMIT = 4000;

    // one expected result item
    typedef struct {
        dsa_pkg::status_t                status;
        logic [dsa_pkg::OFFSET_BITS-1:0] offset;
        logic [dsa_pkg::ADDR_W-1:0]      cpu;
        logic [dsa_pkg::ADDR_W-1:0]      gpu;
    } slot_grant_t;

    // allocator state, configuration and the queue of expected results
    class slot_grant_model;
        logic [dsa_pkg::LIMIT_W-1:0]     limit;
        logic [dsa_pkg::STRIDE_W-1:0]    stride;
        logic [dsa_pkg::ADDR_W-1:0]      cpu_base;
        logic [dsa_pkg::ADDR_W-1:0]      gpu_base;
        logic [dsa_pkg::LIMIT_W-1:0]     bump_next;
        logic [dsa_pkg::OFFSET_BITS-1:0] freed[dsa_pkg::FREE_DEPTH];
        int unsigned                     freed_cnt;
        slot_grant_t                     pending_grants[$];
        int unsigned                     errors;

        function new();
            limit     = '0;
            stride    = dsa_pkg::STRIDE_RESET;
            cpu_base  = '0;
            gpu_base  = '0;
            bump_next = '0;
            freed_cnt = 0;
            errors    = 0;
        endfunction

        function void set_reg(dsa_pkg::cfg_idx_t idx, logic [dsa_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                dsa_pkg::CFG_SLOT_LIMIT:  limit = data[dsa_pkg::LIMIT_W-1:0];
                dsa_pkg::CFG_SLOT_STRIDE: stride = data[dsa_pkg::STRIDE_W-1:0];
                dsa_pkg::CFG_CPU_BASE:    cpu_base = data;
                dsa_pkg::CFG_GPU_BASE:    gpu_base = data;
                default: ;
            endcase
        endfunction

        // work out the result of one accepted request item
        function void note_request(logic rt, logic [dsa_pkg::COUNT_W-1:0] cnt,
                                   logic [dsa_pkg::OFFSET_BITS-1:0] ofs);
            slot_grant_t                     g;
            logic [dsa_pkg::LIMIT_W-1:0]     cap_lim;
            logic [dsa_pkg::OFFSET_BITS-1:0] o;
            logic                            granted;
            g.status = dsa_pkg::ST_NOSPACE;
            g.offset = '0;
            g.cpu    = '0;
            g.gpu    = '0;
            granted  = 1'b0;
            o        = '0;
            if (rt == dsa_pkg::REQ_FREE)
            begin
                if (freed_cnt >= dsa_pkg::FREE_DEPTH)
                begin
                    g.status = dsa_pkg::ST_DROPPED;
                end
                else
                begin
                    freed[freed_cnt] = ofs;
                    freed_cnt++;
                    g.status = dsa_pkg::ST_FREED;
                end
            end
            else if (freed_cnt > 0)
            begin
                // reuse of a freed slot ignores the count
                freed_cnt--;
                o = freed[freed_cnt];
                granted = 1'b1;
            end
            else
            begin
                cap_lim = (limit > dsa_pkg::LIMIT_CAP) ? dsa_pkg::LIMIT_CAP : limit;
                if (cnt != 0 && (26'(bump_next) + 26'(cnt)) <= 26'(cap_lim))
                begin
                    o = bump_next[dsa_pkg::OFFSET_BITS-1:0];
                    bump_next = bump_next + dsa_pkg::LIMIT_W'(cnt);
                    granted = 1'b1;
                end
            end
            if (granted)
            begin
                g.status = dsa_pkg::ST_GRANTED;
                g.offset = o;
                g.cpu    = cpu_base + 64'(o) * 64'(stride);
                g.gpu    = gpu_base + 64'(o) * 64'(stride);
            end
            pending_grants.insert(pending_grants.size(), g);
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch at %0t: %s", $realtime, msg);
        endfunction

        // compare one result item against the oldest expectation
        function void check_grant(logic [1:0] st, logic [dsa_pkg::OFFSET_BITS-1:0] ofs,
                                  logic [dsa_pkg::ADDR_W-1:0] cpu,
                                  logic [dsa_pkg::ADDR_W-1:0] gpu);
            slot_grant_t g;
            if (pending_grants.size() == 0)
            begin
                note_error($sformatf("unexpected result status %0d offset %h", st, ofs));
                return;
            end
            g = pending_grants.pop_front();
            if (st !== g.status || ofs !== g.offset || cpu !== g.cpu || gpu !== g.gpu)
                note_error($sformatf(
                    "exp/act status %0d/%0d offset %h/%h cpu %h/%h gpu %h/%h",
                    g.status, st, g.offset, ofs, g.cpu, cpu, g.gpu, gpu));
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [dsa_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [dsa_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic                            req_type = dsa_pkg::REQ_ALLOC;
    logic [dsa_pkg::COUNT_W-1:0]     alloc_count = '0;
    logic [dsa_pkg::OFFSET_BITS-1:0] free_offset = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [1:0]                      status;
    logic [dsa_pkg::OFFSET_BITS-1:0] slot_offset;
    logic [dsa_pkg::ADDR_W-1:0]      cpu_address;
    logic [dsa_pkg::ADDR_W-1:0]      gpu_address;

    slot_grant_model                 grant_model;
    logic [dsa_pkg::OFFSET_BITS-1:0] live_offsets[$];
    bit                              calm = 1'b0;
    int                              stall_cycles = 0;

    descriptor_slot_allocator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .alloc_count (alloc_count),
        .free_offset (free_offset),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .slot_offset (slot_offset),
        .cpu_address (cpu_address),
        .gpu_address (gpu_address)
    );

    always #6 clk = ~clk;

    // receiver stalls now and then, never during a calm stretch
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= 12);

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            grant_model.check_grant(status, slot_offset, cpu_address, gpu_address);
            if (status == dsa_pkg::ST_GRANTED)
                live_offsets.insert(live_offsets.size(), slot_offset);
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // one register write, write enable left high for a following write
    task automatic write_reg(input dsa_pkg::cfg_idx_t idx,
                             input logic [dsa_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        grant_model.set_reg(idx, data);
    endtask

    task automatic configure(input logic [dsa_pkg::LIMIT_W-1:0] lim,
                             input logic [dsa_pkg::STRIDE_W-1:0] strd,
                             input logic [dsa_pkg::ADDR_W-1:0] cbase,
                             input logic [dsa_pkg::ADDR_W-1:0] gbase);
        write_reg(dsa_pkg::CFG_SLOT_LIMIT, 64'(lim));
        write_reg(dsa_pkg::CFG_SLOT_STRIDE, 64'(strd));
        write_reg(dsa_pkg::CFG_CPU_BASE, cbase);
        write_reg(dsa_pkg::CFG_GPU_BASE, gbase);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // present one request item and wait for its acceptance
    task automatic send_request(input logic rt, input logic [dsa_pkg::COUNT_W-1:0] cnt,
                                input logic [dsa_pkg::OFFSET_BITS-1:0] ofs);
        if (!calm && $urandom_range(0, 99) < 12)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < 50);
        end
        in_valid    <= 1'b1;
        req_type    <= rt;
        alloc_count <= cnt;
        free_offset <= ofs;
        do @(posedge clk); while (!in_ready);
        grant_model.note_request(rt, cnt, ofs);
    endtask

    // drop valid and wait until every expected result has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (grant_model.pending_grants.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [dsa_pkg::COUNT_W-1:0] pick_count(input bit wide);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (wide && r < 8)
            return '1;
        if (wide && r < 60)
            return dsa_pkg::COUNT_W'($urandom_range(0, 65535));
        if (r < 85)
            return dsa_pkg::COUNT_W'($urandom_range(1, 8));
        return dsa_pkg::COUNT_W'($urandom_range(1, 64));
    endfunction

    // mostly hand back offsets that were granted, sometimes anything
    function automatic logic [dsa_pkg::OFFSET_BITS-1:0] pick_free_offset();
        int                              idx;
        logic [dsa_pkg::OFFSET_BITS-1:0] o;
        if (live_offsets.size() != 0 && $urandom_range(0, 99) < 70)
        begin
            idx = $urandom_range(0, live_offsets.size() - 1);
            o = live_offsets[idx];
            live_offsets.delete(idx);
        end
        else if ($urandom_range(0, 1))
        begin
            o = dsa_pkg::OFFSET_BITS'($urandom_range(0, 255));
        end
        else
        begin
            o = dsa_pkg::OFFSET_BITS'($urandom);
        end
        return o;
    endfunction

    // random mix of allocate and free items with junk in the unused field
    task automatic run_mix(input int n, input bit wide, input int alloc_pct);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < alloc_pct)
                send_request(dsa_pkg::REQ_ALLOC, pick_count(wide),
                             dsa_pkg::OFFSET_BITS'($urandom));
            else
                send_request(dsa_pkg::REQ_FREE, dsa_pkg::COUNT_W'($urandom),
                             pick_free_offset());
        end
    endtask

    function automatic logic [dsa_pkg::ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        int n_fill;
        grant_model = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero limit, empty stack, reuse ignores the count
        send_request(dsa_pkg::REQ_ALLOC, 16'd1, '0);
        send_request(dsa_pkg::REQ_ALLOC, 16'd0, '0);
        send_request(dsa_pkg::REQ_FREE, 16'hFFFF, 24'd0);
        send_request(dsa_pkg::REQ_ALLOC, 16'd0, 24'hFFFFFF);
        send_request(dsa_pkg::REQ_FREE, 16'd0, 24'hFFFFFF);
        send_request(dsa_pkg::REQ_ALLOC, 16'hFFFF, '0);
        settle();

        // exact bound, zero count, lifo order, address wrap
        configure(25'd100, 13'd4096, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
        send_request(dsa_pkg::REQ_ALLOC, 16'd1, '0);
        send_request(dsa_pkg::REQ_ALLOC, 16'd99, '0);
        send_request(dsa_pkg::REQ_ALLOC, 16'd1, '0);
        send_request(dsa_pkg::REQ_ALLOC, 16'd0, '0);
        send_request(dsa_pkg::REQ_FREE, 16'd0, 24'd5);
        send_request(dsa_pkg::REQ_FREE, 16'd0, 24'd7);
        send_request(dsa_pkg::REQ_ALLOC, 16'd3, '0);
        send_request(dsa_pkg::REQ_ALLOC, 16'd3, '0);
        settle();

        // limit lowered below the bump counter
        configure(25'd50, 13'h1FFF, '0, '0);
        send_request(dsa_pkg::REQ_ALLOC, 16'd1, '0);
        send_request(dsa_pkg::REQ_FREE, 16'd0, 24'd3);
        send_request(dsa_pkg::REQ_ALLOC, 16'd1, '0);
        send_request(dsa_pkg::REQ_ALLOC, 16'd1, '0);
        settle();

        // oversized limit is clamped to the offset range
        configure(25'h1FFFFFF, 13'd1, rand64(), rand64());
        send_request(dsa_pkg::REQ_ALLOC, 16'hFFFF, '0);
        send_request(dsa_pkg::REQ_FREE, 16'd0, 24'hAAAAAA);
        send_request(dsa_pkg::REQ_FREE, 16'd0, 24'h555555);
        send_request(dsa_pkg::REQ_ALLOC, 16'd0, '0);
        send_request(dsa_pkg::REQ_ALLOC, 16'd0, '0);
        settle();

        // scarce slots, small runs
        configure(grant_model.bump_next + 25'd64, dsa_pkg::STRIDE_W'($urandom_range(0, 64)),
                  rand64(), rand64());
        run_mix(40, 1'b0, 55);
        settle();

        // random limit and stride, wide runs
        configure(grant_model.bump_next + dsa_pkg::LIMIT_W'($urandom_range(0, 50000)),
                  dsa_pkg::STRIDE_W'($urandom_range(0, 4096)), rand64(), rand64());
        run_mix(40, 1'b1, 55);
        settle();

        // full offset range, no idling on either side
        calm = 1'b1;
        configure(dsa_pkg::LIMIT_CAP, 13'd4096, rand64(), '0);
        run_mix(100, 1'b1, 65);
        settle();
        calm = 1'b0;

        // fill the free stack past its depth, then drain some of it
        configure(25'h1FFFFFF, 13'd0, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        n_fill = dsa_pkg::FREE_DEPTH + 8 - int'(grant_model.freed_cnt);
        for (int i = 0; i < n_fill; i++)
            send_request(dsa_pkg::REQ_FREE, dsa_pkg::COUNT_W'($urandom),
                         dsa_pkg::OFFSET_BITS'($urandom));
        run_mix(40, 1'b1, 70);
        settle();

        repeat (6) @(posedge clk);
        if (grant_model.errors == 0 && grant_model.pending_grants.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/dsa_pkg.sv
hdl/dsa_free_stack.sv
hdl/dsa_bump.sv
hdl/dsa_addr_gen.sv
hdl/descriptor_slot_allocator.sv
hdl/dsa_checker.sv
tb/tb_descriptor_slot_allocator.sv
